@@ hw/rtl/sfr_pkg.sv @@
// Shared types and constants for the SYN flood rate detector.
// Used by every module of the block except sfr_ram; depends on nothing.
`timescale 1ns / 1ps

package sfr_pkg;

	typedef enum logic [2:0] {
		V_SHORT    = 3'd0,
		V_NOT_TCP  = 3'd1,
		V_PORT     = 3'd2,
		V_NOT_SYN  = 3'd3,
		V_LOOPBACK = 3'd4,
		V_COUNTED  = 3'd5,
		V_ALERTED  = 3'd6
	} verdict_t;

	typedef enum logic [1:0] {
		REG_TARGET_PORT   = 2'd0,
		REG_SYN_THRESHOLD = 2'd1,
		REG_WINDOW_TICKS  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BS_CLEAR,
		BS_IDLE,
		BS_UPDATE
	} back_state_t;

	localparam int TABLE_ENTRIES = 1024;

	localparam logic [15:0] PORT_HTTPS     = 16'd443;
	localparam logic [15:0] PORT_ALT       = 16'd8000;
	localparam logic [7:0]  FLAG_SYN       = 8'h02;
	localparam logic [7:0]  FLAG_ACK       = 8'h10;
	localparam logic [31:0] ADDR_LOOPBACK  = 32'h7F00_0001;
	localparam logic [31:0] ADDR_ZERO      = 32'h0000_0000;
	localparam logic [15:0] MIN_PACKET     = 16'd40;
	localparam logic [15:0] TCP_HDR_BYTES  = 16'd20;
	localparam logic [3:0]  IP_VERSION_4   = 4'd4;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

	localparam logic [15:0] TARGET_PORT_RST   = 16'd80;
	localparam logic [15:0] SYN_THRESHOLD_RST = 16'd150;
	localparam logic [31:0] WINDOW_TICKS_RST  = 32'd1000;

	// One classified request on its way from the front to the back.
	typedef struct packed {
		verdict_t    verdict;
		logic [31:0] src_address;
		logic [31:0] timestamp;
	} item_t;

	// One tracker in the source table.
	typedef struct packed {
		logic        valid;
		logic [31:0] tag;
		logic [31:0] win_origin;
		logic [15:0] syn_total;
		logic        flagged;
	} entry_t;

	typedef struct packed {
		logic [15:0] window_count;
		logic [31:0] alert_address;
		logic        alert;
		verdict_t    verdict;
	} result_t;

endpackage

@@ hw/rtl/syn_flood_rate_detector.sv @@
// Top level of the SYN flood rate detector: configuration registers, front
// classifier, request queue and table back end. Depends on sfr_pkg, sfr_front,
// sfr_queue and sfr_back.
//
// Usage. Header summaries enter on the s_axis channel and exactly one verdict
// per request leaves on the m_axis channel, in order. Registers are written
// through cfg_wen/cfg_index/cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce. A dropped request
// is finished by the back end in its idle state; a request that reaches the
// source table is read from the registered table port and written back in the
// update state. An accepted request passes the queue and the result register.
// After reset the back end clears the table, one entry a cycle, and
// s_axis_tready stays low until all 1024 entries are cleared.
// The table holds 1024 sources; the low ten address bits index it.
// When the receiver stalls, the result register holds, the back end stops and
// the queue of QUEUE_DEPTH requests fills before s_axis_tready drops.
`timescale 1ns / 1ps

module syn_flood_rate_detector #(
	parameter int QUEUE_DEPTH   = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// ip_version[3:0], header_words[7:4], protocol[15:8], packet_length[31:16],
	// src_address[63:32], dest_port[79:64], tcp_flags[87:80], timestamp[119:88]
	input  logic [119:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// verdict[2:0], alert[3], alert_address[35:4], window_count[51:36], zeros above
	output logic [55:0]  m_axis_tdata,
	input  logic         cfg_wen,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	logic [15:0]      target_port_q;
	logic [15:0]      syn_threshold_q;
	logic [31:0]      window_ticks_q;

	logic             clearing;
	logic             queue_full;
	logic             push;
	sfr_pkg::item_t   push_item;
	logic             q_valid;
	sfr_pkg::item_t   q_item;
	logic             q_pop;
	sfr_pkg::result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_port_q   <= sfr_pkg::TARGET_PORT_RST;
			syn_threshold_q <= sfr_pkg::SYN_THRESHOLD_RST;
			window_ticks_q  <= sfr_pkg::WINDOW_TICKS_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				sfr_pkg::REG_TARGET_PORT:   target_port_q   <= cfg_data[15:0];
				sfr_pkg::REG_SYN_THRESHOLD: syn_threshold_q <= cfg_data[15:0];
				sfr_pkg::REG_WINDOW_TICKS:  window_ticks_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	sfr_front u_front (
		.s_valid      (s_axis_tvalid),
		.s_ready      (s_axis_tready),
		.ip_version   (s_axis_tdata[3:0]),
		.header_words (s_axis_tdata[7:4]),
		.protocol     (s_axis_tdata[15:8]),
		.packet_length(s_axis_tdata[31:16]),
		.src_address  (s_axis_tdata[63:32]),
		.dest_port    (s_axis_tdata[79:64]),
		.tcp_flags    (s_axis_tdata[87:80]),
		.timestamp    (s_axis_tdata[119:88]),
		.target_port  (target_port_q),
		.clearing     (clearing),
		.queue_full   (queue_full),
		.push         (push),
		.push_item    (push_item)
	);

	sfr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (q_pop),
		.head_valid(q_valid),
		.head_item (q_item)
	);

	sfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.syn_threshold(syn_threshold_q),
		.window_ticks (window_ticks_q),
		.clearing     (clearing),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_result   (result)
	);

	assign m_axis_tdata = {4'd0, result};

	// No request is taken while the table is being cleared.
	assert property (@(posedge clk) disable iff (!arst_n) clearing |-> !s_axis_tready)
		else $error("request accepted during table clear");

	// The queue never takes a request when it is full.
	assert property (@(posedge clk) disable iff (!arst_n) queue_full |-> !push)
		else $error("queue overflow");

	// An alert always comes with the alerted verdict and a real source address.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && result.alert) |->
			(result.verdict == sfr_pkg::V_ALERTED && result.alert_address != 32'd0))
		else $error("alert without alerted verdict");

	// A counted or alerted result always carries a non-zero window count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (result.verdict == sfr_pkg::V_COUNTED
			|| result.verdict == sfr_pkg::V_ALERTED)) |-> result.window_count != 16'd0)
		else $error("counted result with zero count");

endmodule

@@ hw/rtl/sfr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module sfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/sfr_queue.sv @@
// Short request queue between the classifying front and the table back end.
// Depends on sfr_pkg for the item type.
`timescale 1ns / 1ps

module sfr_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfr_pkg::item_t push_item,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output sfr_pkg::item_t head_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sfr_pkg::item_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ hw/rtl/sfr_front.sv @@
// Front end: takes header summaries and classifies them into drop verdicts
// or table lookups. Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_front (
	input  logic           s_valid,
	output logic           s_ready,
	input  logic [3:0]     ip_version,
	input  logic [3:0]     header_words,
	input  logic [7:0]     protocol,
	input  logic [15:0]    packet_length,
	input  logic [31:0]    src_address,
	input  logic [15:0]    dest_port,
	input  logic [7:0]     tcp_flags,
	input  logic [31:0]    timestamp,
	input  logic [15:0]    target_port,
	input  logic           clearing,
	input  logic           queue_full,
	output logic           push,
	output sfr_pkg::item_t push_item
);

	logic [15:0] min_len;

	assign s_ready = !queue_full && !clearing;
	assign push    = s_valid && s_ready;
	assign min_len = {10'd0, header_words, 2'b00} + sfr_pkg::TCP_HDR_BYTES;

	always_comb begin
		push_item.src_address = src_address;
		push_item.timestamp   = timestamp;
		if (packet_length < sfr_pkg::MIN_PACKET) begin
			push_item.verdict = sfr_pkg::V_SHORT;
		end else if (ip_version != sfr_pkg::IP_VERSION_4 || protocol != sfr_pkg::PROTO_TCP) begin
			push_item.verdict = sfr_pkg::V_NOT_TCP;
		end else if (packet_length < min_len) begin
			push_item.verdict = sfr_pkg::V_SHORT;
		end else if (dest_port != target_port && dest_port != sfr_pkg::PORT_HTTPS
				&& dest_port != sfr_pkg::PORT_ALT) begin
			push_item.verdict = sfr_pkg::V_PORT;
		end else if ((tcp_flags & sfr_pkg::FLAG_SYN) == 8'd0
				|| (tcp_flags & sfr_pkg::FLAG_ACK) != 8'd0) begin
			push_item.verdict = sfr_pkg::V_NOT_SYN;
		end else if (src_address == sfr_pkg::ADDR_LOOPBACK
				|| src_address == sfr_pkg::ADDR_ZERO) begin
			push_item.verdict = sfr_pkg::V_LOOPBACK;
		end else begin
			// Passed every filter: the back end looks the source up.
			push_item.verdict = sfr_pkg::V_COUNTED;
		end
	end

endmodule

@@ hw/rtl/sfr_back.sv @@
// Back end: clears the source table after reset, then performs one table
// read-modify-write per counted request and drives the result register.
// Depends on sfr_pkg and sfr_ram.
`timescale 1ns / 1ps

module sfr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  sfr_pkg::item_t  q_item,
	output logic            q_pop,
	input  logic [15:0]     syn_threshold,
	input  logic [31:0]     window_ticks,
	output logic            clearing,
	output logic            out_valid,
	input  logic            out_ready,
	output sfr_pkg::result_t out_result
);

	localparam int IDX_W = $clog2(sfr_pkg::TABLE_ENTRIES);
	localparam int ENTRY_W = $bits(sfr_pkg::entry_t);

	sfr_pkg::back_state_t state_q, state_d;

	logic [IDX_W-1:0]   clr_idx_q;
	logic [31:0]        addr_q;
	logic [31:0]        now_q;
	logic               out_valid_q;
	sfr_pkg::result_t   out_q;

	logic               out_free;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	sfr_pkg::entry_t    ram_wentry;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_rdata;
	sfr_pkg::entry_t    rd_entry;
	logic               take_lookup;
	logic               load_out;
	sfr_pkg::result_t   res_d;

	logic [31:0]        elapsed;
	logic               hit;
	logic               expired;
	logic [15:0]        count_inc;
	logic               raise;

	sfr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(sfr_pkg::TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wentry),
		.re   (ram_re),
		.raddr(q_item.src_address[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_entry   = sfr_pkg::entry_t'(ram_rdata);
	assign out_free   = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign out_result = out_q;
	assign clearing   = (state_q == sfr_pkg::BS_CLEAR);

	assign elapsed   = now_q - rd_entry.win_origin;
	assign hit       = rd_entry.valid && (rd_entry.tag == addr_q);
	assign expired   = (elapsed >= window_ticks);
	assign count_inc = (rd_entry.syn_total == sfr_pkg::COUNT_MAX) ? rd_entry.syn_total
		: rd_entry.syn_total + 16'd1;
	assign raise     = (count_inc > syn_threshold) && !rd_entry.flagged;

	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		ram_re      = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = addr_q[IDX_W-1:0];
		ram_wentry  = '0;
		take_lookup = 1'b0;
		load_out    = 1'b0;
		res_d       = '0;
		res_d.verdict = q_item.verdict;
		unique case (state_q)
			sfr_pkg::BS_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				if (clr_idx_q == IDX_W'(sfr_pkg::TABLE_ENTRIES - 1)) begin
					state_d = sfr_pkg::BS_IDLE;
				end
			end
			sfr_pkg::BS_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (q_item.verdict == sfr_pkg::V_COUNTED) begin
						ram_re      = 1'b1;
						take_lookup = 1'b1;
						state_d     = sfr_pkg::BS_UPDATE;
					end else begin
						load_out = 1'b1;
					end
				end
			end
			sfr_pkg::BS_UPDATE: begin
				if (out_free) begin
					ram_we   = 1'b1;
					load_out = 1'b1;
					state_d  = sfr_pkg::BS_IDLE;
					res_d.verdict = sfr_pkg::V_COUNTED;
					if (!hit || expired) begin
						ram_wentry.valid      = 1'b1;
						ram_wentry.tag        = addr_q;
						ram_wentry.win_origin = now_q;
						ram_wentry.syn_total  = 16'd1;
						ram_wentry.flagged    = 1'b0;
						res_d.window_count    = 16'd1;
					end else begin
						ram_wentry.valid      = 1'b1;
						ram_wentry.tag        = rd_entry.tag;
						ram_wentry.win_origin = rd_entry.win_origin;
						ram_wentry.syn_total  = count_inc;
						ram_wentry.flagged    = rd_entry.flagged || raise;
						res_d.window_count    = count_inc;
						if (raise) begin
							res_d.verdict       = sfr_pkg::V_ALERTED;
							res_d.alert         = 1'b1;
							res_d.alert_address = addr_q;
						end
					end
				end
			end
			default: begin
				state_d = sfr_pkg::BS_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sfr_pkg::BS_CLEAR;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sfr_pkg::BS_CLEAR) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_lookup) begin
			addr_q <= q_item.src_address;
			now_q  <= q_item.timestamp;
		end
		if (load_out) begin
			out_q <= res_d;
		end
	end

endmodule
